### hdl/izba_pkg.sv
package izba_pkg;

  typedef enum logic [1:0] {
    MODE_ALLOC_INODE = 2'd0,
    MODE_FREE_INODE  = 2'd1,
    MODE_ALLOC_ZONE  = 2'd2,
    MODE_FREE_ZONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_CHECK,
    ST_DONE
  } state_t;

  localparam logic [1:0] CFG_INODE_BLOCKS = 2'd0;
  localparam logic [1:0] CFG_ZONE_BLOCKS  = 2'd1;
  localparam logic [1:0] CFG_FIRST_ZONE   = 2'd2;

  localparam logic [7:0] BYTE_FULL = 8'hff;
  localparam logic [15:0] NUMBER_MAX = 16'hffff;

endpackage

### hdl/inode_zone_bitmap_allocator_core.sv
// Inode and zone bitmap allocator.
// Input channel (in_valid/in_ready) takes one request beat: in_mode selects
// allocate or free of an inode or a zone, in_number is the number to free.
// Output channel (out_valid/out_ready) returns one beat per request with
// out_granted and out_status (ok, map full, out of range).
// The cfg_ port writes block counts and the first data zone; write it only
// while no request is in flight.
// One request is worked at a time; in_ready rises with out_valid. A free
// passes ISSUE, CHECK (read-modify-write) and DONE, or goes from ISSUE to
// DONE when the number is out of range or its byte was never written. An
// allocate reads a byte in ISSUE and tests it in CHECK, back to ISSUE for
// each full byte; at the fill mark it writes from ISSUE and goes to DONE.
// The scan starts at a per-map hint (lowest byte that may hold a clear
// bit). The byte-wide map memories have a registered read. Reset (rst_n
// low, synchronous) clears the state, out_valid, the hints and the fill
// marks and sets one block per map and first zone 0; bytes at or above a
// map's fill mark read as never written, so no clearing pass is needed and
// requests are taken right after reset. While out_ready is low a finished
// result holds in the output register; the next request is accepted, but
// its result waits until that beat is taken.
module inode_zone_bitmap_allocator_core #(
  parameter int BLOCK_BYTES      = 1024,
  parameter int MAX_INODE_BLOCKS = 2,
  parameter int MAX_ZONE_BLOCKS  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_granted,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import izba_pkg::*;

  localparam int IDEPTH = MAX_INODE_BLOCKS * BLOCK_BYTES;
  localparam int ZDEPTH = MAX_ZONE_BLOCKS * BLOCK_BYTES;
  localparam int MDEPTH = (IDEPTH > ZDEPTH) ? IDEPTH : ZDEPTH;
  localparam int CW     = $clog2(MDEPTH + 1);
  localparam int IAW    = $clog2(IDEPTH);
  localparam int ZAW    = $clog2(ZDEPTH);
  localparam int EW     = (CW + 4 > 18) ? CW + 4 : 18;

  state_t        state_r, state_nxt;
  mode_t         mode_r, mode_nxt;
  logic [15:0]   number_r, number_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic [2:0]    bitk_r, bitk_nxt;
  logic [CW-1:0] ihint_r, ihint_nxt, ihwm_r, ihwm_nxt;
  logic [CW-1:0] zhint_r, zhint_nxt, zhwm_r, zhwm_nxt;
  logic [15:0]   res_granted_r, res_granted_nxt;
  status_t       res_status_r, res_status_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [15:0]   out_granted_r, out_granted_nxt;
  status_t       out_status_r, out_status_nxt;
  logic [1:0]    inode_blocks_r;
  logic [3:0]    zone_blocks_r;
  logic [15:0]   first_zone_r;

  logic          map_z, is_alloc;
  logic [3:0]    iblk_c, zblk_c;
  logic [CW-1:0] inbytes, znbytes, nbytes_sel, hint_sel, hwm_sel;
  logic [7:0]    irdata, zrdata, rd_sel, byte_val, set_byte;
  logic [2:0]    kz;
  logic [EW-1:0] ext_num, ext_fdz, fbit, fbyte, abit, zsum;
  logic          zone_low, free_bad, alloc_bad;
  logic [CW-1:0] fidx, rd_idx;
  logic [15:0]   agrant;
  logic          wr_en;
  logic [7:0]    wr_data;

  assign map_z    = mode_r[1];
  assign is_alloc = (mode_r == MODE_ALLOC_INODE) || (mode_r == MODE_ALLOC_ZONE);

  always_comb begin
    iblk_c = ({2'b00, inode_blocks_r} > 4'(MAX_INODE_BLOCKS)) ?
             4'(MAX_INODE_BLOCKS) : {2'b00, inode_blocks_r};
    zblk_c = (zone_blocks_r > 4'(MAX_ZONE_BLOCKS)) ? 4'(MAX_ZONE_BLOCKS) : zone_blocks_r;
    inbytes = CW'(iblk_c) * CW'(BLOCK_BYTES);
    znbytes = CW'(zblk_c) * CW'(BLOCK_BYTES);
  end

  assign nbytes_sel = map_z ? znbytes : inbytes;
  assign hint_sel   = map_z ? zhint_r : ihint_r;
  assign hwm_sel    = map_z ? zhwm_r : ihwm_r;
  assign rd_sel     = map_z ? zrdata : irdata;

  // free: number to bit index and range check
  always_comb begin
    ext_num  = EW'(number_r);
    ext_fdz  = EW'(first_zone_r);
    zone_low = map_z && ((ext_num + EW'(1)) < ext_fdz);
    fbit     = map_z ? (ext_num + EW'(1) - ext_fdz) : ext_num;
    fbyte    = fbit >> 3;
    free_bad = zone_low || (fbit == '0) || (fbyte >= EW'(nbytes_sel));
    fidx     = fbyte[CW-1:0];
  end

  // allocate: lowest clear bit of the current byte
  always_comb begin
    byte_val = (state_r == ST_CHECK) ? rd_sel : ((cur_r == '0) ? 8'h01 : 8'h00);
    kz = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (!byte_val[k]) begin
        kz = 3'(k);
      end
    end
    set_byte  = byte_val | (8'b1 << kz);
    abit      = EW'({cur_r, kz});
    zsum      = abit + ext_fdz;
    alloc_bad = map_z ? ((abit == '0) || ((zsum - EW'(1)) > EW'(NUMBER_MAX)))
                      : (abit > EW'(NUMBER_MAX));
    agrant    = map_z ? zsum[15:0] - 16'd1 : abit[15:0];
  end

  assign rd_idx = (state_r == ST_ISSUE && !is_alloc) ? fidx : cur_r;

  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    number_nxt      = number_r;
    cur_nxt         = cur_r;
    bitk_nxt        = bitk_r;
    ihint_nxt       = ihint_r;
    ihwm_nxt        = ihwm_r;
    zhint_nxt       = zhint_r;
    zhwm_nxt        = zhwm_r;
    res_granted_nxt = res_granted_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_granted_nxt = out_granted_r;
    out_status_nxt  = out_status_r;
    wr_en           = 1'b0;
    wr_data         = set_byte;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt        = mode_t'(in_mode);
          number_nxt      = in_number;
          cur_nxt         = in_mode[1] ? zhint_r : ihint_r;
          res_granted_nxt = 16'd0;
          res_status_nxt  = STATUS_OK;
          state_nxt       = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (is_alloc) begin
          if (cur_r >= nbytes_sel) begin
            res_status_nxt = STATUS_FULL;
            state_nxt      = ST_DONE;
          end else if (cur_r == hwm_sel) begin
            if (alloc_bad) begin
              res_status_nxt = STATUS_RANGE;
            end else begin
              wr_en           = 1'b1;
              res_granted_nxt = agrant;
              if (map_z) begin
                zhwm_nxt = zhwm_r + CW'(1);
              end else begin
                ihwm_nxt = ihwm_r + CW'(1);
              end
            end
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_CHECK;
          end
        end else begin
          if (free_bad) begin
            res_status_nxt = STATUS_RANGE;
            state_nxt      = ST_DONE;
          end else if (fidx >= hwm_sel) begin
            state_nxt = ST_DONE;
          end else begin
            cur_nxt   = fidx;
            bitk_nxt  = fbit[2:0];
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (is_alloc) begin
          if (rd_sel == BYTE_FULL) begin
            cur_nxt = cur_r + CW'(1);
            if (map_z) begin
              zhint_nxt = cur_r + CW'(1);
            end else begin
              ihint_nxt = cur_r + CW'(1);
            end
            state_nxt = ST_ISSUE;
          end else begin
            if (alloc_bad) begin
              res_status_nxt = STATUS_RANGE;
            end else begin
              wr_en           = 1'b1;
              res_granted_nxt = agrant;
            end
            state_nxt = ST_DONE;
          end
        end else begin
          wr_en   = 1'b1;
          wr_data = rd_sel & ~(8'b1 << bitk_r);
          if (cur_r < hint_sel) begin
            if (map_z) begin
              zhint_nxt = cur_r;
            end else begin
              ihint_nxt = cur_r;
            end
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = res_granted_r;
          out_status_nxt  = res_status_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      ihint_r        <= '0;
      ihwm_r         <= '0;
      zhint_r        <= '0;
      zhwm_r         <= '0;
      inode_blocks_r <= 2'd1;
      zone_blocks_r  <= 4'd1;
      first_zone_r   <= 16'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ihint_r     <= ihint_nxt;
      ihwm_r      <= ihwm_nxt;
      zhint_r     <= zhint_nxt;
      zhwm_r      <= zhwm_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_INODE_BLOCKS: inode_blocks_r <= cfg_wdata[1:0];
          CFG_ZONE_BLOCKS:  zone_blocks_r  <= cfg_wdata[3:0];
          CFG_FIRST_ZONE:   first_zone_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r        <= mode_nxt;
    number_r      <= number_nxt;
    cur_r         <= cur_nxt;
    bitk_r        <= bitk_nxt;
    res_granted_r <= res_granted_nxt;
    res_status_r  <= res_status_nxt;
    out_granted_r <= out_granted_nxt;
    out_status_r  <= out_status_nxt;
  end

  izba_ram #(.WIDTH(8), .DEPTH(IDEPTH)) u_inode_ram (
    .clk   (clk),
    .we    (wr_en && !map_z),
    .waddr (cur_r[IAW-1:0]),
    .wdata (wr_data),
    .raddr (rd_idx[IAW-1:0]),
    .rdata (irdata)
  );

  izba_ram #(.WIDTH(8), .DEPTH(ZDEPTH)) u_zone_ram (
    .clk   (clk),
    .we    (wr_en && map_z),
    .waddr (cur_r[ZAW-1:0]),
    .wdata (wr_data),
    .raddr (rd_idx[ZAW-1:0]),
    .rdata (zrdata)
  );

  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_granted = out_granted_r;
  assign out_status  = out_status_r;

endmodule

### hdl/izba_ram.sv
module izba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/izba_checker.sv
module izba_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_granted,
  input logic [1:0]  out_status
);
  import izba_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  a_fail_grants_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STATUS_OK) |-> out_granted == 16'd0)
    else $error("nonzero number on failed request");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result beat one cycle after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_granted) && $stable(out_status))
    else $error("stalled result beat changed");

endmodule

bind inode_zone_bitmap_allocator_core izba_checker u_izba_checker (.*);

### sim/inode_zone_bitmap_allocator_core_test.sv
`timescale 1ns / 1ps

module inode_zone_bitmap_allocator_core_test;
  import izba_pkg::*;

  localparam int BLOCK_BYTES      = 1024;
  localparam int MAX_INODE_BLOCKS = 2;
  localparam int MAX_ZONE_BLOCKS  = 8;
  localparam int INODE_BYTES      = MAX_INODE_BLOCKS * BLOCK_BYTES;
  localparam int ZONE_BYTES       = MAX_ZONE_BLOCKS * BLOCK_BYTES;
  localparam int CYCLE_LIMIT      = 2000000;
  localparam int RANDOM_SEGMENT   = 41;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] number;
  } request_t;

  typedef struct packed {
    logic [15:0] granted;
    status_t     status;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = 2'd0;
  logic [15:0] in_number = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_granted;
  logic [1:0]  out_status;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_wdata = 16'd0;

  logic [7:0]  inode_bits [INODE_BYTES];
  logic [7:0]  zone_bits [ZONE_BYTES];
  logic [1:0]  inode_blocks_r = 2'd1;
  logic [3:0]  zone_blocks_r = 4'd1;
  logic [15:0] first_zone_r = 16'd0;

  request_t pending_requests [$];
  grant_t   expected_grants [$];
  int       issued = 0;
  int       received = 0;
  int       errors = 0;
  int       cycles = 0;
  int       send_idle_pct = 36;
  int       recv_idle_pct = 55;
  bit       beat_taken = 1'b0;

  inode_zone_bitmap_allocator_core #(
    .BLOCK_BYTES(BLOCK_BYTES),
    .MAX_INODE_BLOCKS(MAX_INODE_BLOCKS),
    .MAX_ZONE_BLOCKS(MAX_ZONE_BLOCKS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_mode(in_mode),
    .in_number(in_number),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_granted(out_granted),
    .out_status(out_status),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int map_bytes(int blocks, int max_blocks);
    return (blocks > max_blocks ? max_blocks : blocks) * BLOCK_BYTES;
  endfunction

  function automatic int first_free(bit is_zone, int nbytes);
    logic [7:0] c;
    int k;
    for (int i = 0; i < nbytes; i++) begin
      c = is_zone ? zone_bits[i] : inode_bits[i];
      if (c != BYTE_FULL) begin
        k = 0;
        while (k < 7 && c[k]) k++;
        return i * 8 + k;
      end
    end
    return -1;
  endfunction

  function automatic void mark_used(bit is_zone, int b);
    if (is_zone) zone_bits[b >> 3][b & 7] = 1'b1;
    else inode_bits[b >> 3][b & 7] = 1'b1;
  endfunction

  function automatic status_t release_bit(bit is_zone, int nbytes, int b);
    if (b == 0 || (b >> 3) >= nbytes) return STATUS_RANGE;
    if (is_zone) zone_bits[b >> 3][b & 7] = 1'b0;
    else inode_bits[b >> 3][b & 7] = 1'b0;
    return STATUS_OK;
  endfunction

  function automatic grant_t serve_request(request_t req);
    grant_t r;
    int b;
    int z;
    int ibytes;
    int zbytes;
    r.granted = 16'd0;
    r.status = STATUS_OK;
    ibytes = map_bytes(int'(inode_blocks_r), MAX_INODE_BLOCKS);
    zbytes = map_bytes(int'(zone_blocks_r), MAX_ZONE_BLOCKS);
    case (req.mode)
      MODE_ALLOC_INODE: begin
        b = first_free(1'b0, ibytes);
        if (b < 0) begin
          r.status = STATUS_FULL;
        end else if (b > int'(NUMBER_MAX)) begin
          r.status = STATUS_RANGE;
        end else begin
          mark_used(1'b0, b);
          r.granted = b[15:0];
        end
      end
      MODE_FREE_INODE: begin
        r.status = release_bit(1'b0, ibytes, int'(req.number));
      end
      MODE_ALLOC_ZONE: begin
        b = first_free(1'b1, zbytes);
        if (b < 0) begin
          r.status = STATUS_FULL;
        end else begin
          z = b + int'(first_zone_r) - 1;
          if (b == 0 || z > int'(NUMBER_MAX)) begin
            r.status = STATUS_RANGE;
          end else begin
            mark_used(1'b1, b);
            r.granted = z[15:0];
          end
        end
      end
      default: begin
        if (int'(req.number) + 1 < int'(first_zone_r)) r.status = STATUS_RANGE;
        else r.status = release_bit(1'b1, zbytes,
                                    int'(req.number) + 1 - int'(first_zone_r));
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= 50) $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  task automatic add_request(mode_t mode, logic [15:0] number);
    request_t q;
    q.mode = mode;
    q.number = number;
    pending_requests.push_back(q);
    issued++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_INODE_BLOCKS: inode_blocks_r = val[1:0];
      CFG_ZONE_BLOCKS:  zone_blocks_r = val[3:0];
      default:          first_zone_r = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || received != issued) @(posedge clk);
  endtask

  task automatic random_config();
    int r;
    logic [15:0] fz;
    r = $urandom_range(9);
    write_reg(CFG_INODE_BLOCKS, r == 0 ? 16'd0 : r < 5 ? 16'd1 : r < 9 ? 16'd2 : 16'd3);
    r = $urandom_range(19);
    write_reg(CFG_ZONE_BLOCKS, r == 0 ? 16'd0 :
              r < 17 ? 16'($urandom_range(1, 8)) : 16'($urandom_range(9, 15)));
    case ($urandom_range(4))
      0: fz = 16'd0;
      1: fz = 16'hffff;
      2: fz = 16'($urandom_range(0, 255));
      3: fz = 16'hffff - 16'($urandom_range(0, 60));
      default: fz = 16'($urandom_range(0, 65535));
    endcase
    write_reg(CFG_FIRST_ZONE, fz);
  endtask

  task automatic random_requests(int count);
    int r;
    int ibits;
    int zbits;
    logic [15:0] n;
    ibits = map_bytes(int'(inode_blocks_r), MAX_INODE_BLOCKS) * 8;
    zbits = map_bytes(int'(zone_blocks_r), MAX_ZONE_BLOCKS) * 8;
    repeat (count) begin
      r = $urandom_range(99);
      n = 16'($urandom_range(0, 65535));
      if (r < 25) begin
        add_request(MODE_ALLOC_INODE, n);
      end else if (r < 45) begin
        r = $urandom_range(99);
        if (r < 70) n = 16'($urandom_range(0, 80));
        else if (r < 85) n = 16'(ibits - 1 + $urandom_range(0, 2));
        add_request(MODE_FREE_INODE, n);
      end else if (r < 70) begin
        add_request(MODE_ALLOC_ZONE, n);
      end else begin
        r = $urandom_range(99);
        if (r < 70) n = first_zone_r + 16'($urandom_range(0, 80)) - 16'd1;
        else if (r < 85) n = first_zone_r + 16'(zbits - 2 + $urandom_range(0, 2));
        add_request(MODE_FREE_ZONE, n);
      end
    end
  endtask

  task automatic random_phase();
    repeat (3) begin
      random_config();
      random_requests(RANDOM_SEGMENT);
      wait_drained();
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL inode_zone_bitmap_allocator_core");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_grants.push_back(serve_request({mode_t'(in_mode), in_number}));
      beat_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && (!in_valid || beat_taken)) begin
      beat_taken = 1'b0;
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_mode <= pending_requests[0].mode;
        in_number <= pending_requests[0].number;
        void'(pending_requests.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    grant_t exp;
    if (rst_n && out_valid && out_ready) begin
      received++;
      if (expected_grants.size() == 0) begin
        report_mismatch($sformatf("unexpected beat granted %0d status %0d",
                                  out_granted, out_status));
      end else begin
        exp = expected_grants.pop_front();
        if (out_granted !== exp.granted)
          report_mismatch($sformatf("granted %0d, expected %0d", out_granted, exp.granted));
        if (out_status !== exp.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_status, exp.status));
      end
    end
  end

  initial begin
    for (int i = 0; i < INODE_BYTES; i++) inode_bits[i] = 8'd0;
    for (int i = 0; i < ZONE_BYTES; i++) zone_bits[i] = 8'd0;
    inode_bits[0] = 8'd1;
    zone_bits[0] = 8'd1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    repeat (3) add_request(MODE_ALLOC_INODE, 16'hffff);
    add_request(MODE_FREE_INODE, 16'd2);
    add_request(MODE_ALLOC_INODE, 16'd0);
    add_request(MODE_FREE_INODE, 16'd0);
    add_request(MODE_FREE_INODE, 16'hffff);
    add_request(MODE_FREE_INODE, 16'd8191);
    add_request(MODE_FREE_INODE, 16'd8192);
    repeat (2) add_request(MODE_ALLOC_ZONE, 16'h5555);
    add_request(MODE_FREE_ZONE, 16'd0);
    add_request(MODE_FREE_ZONE, 16'hffff);
    add_request(MODE_FREE_ZONE, 16'd0);
    wait_drained();
    write_reg(CFG_FIRST_ZONE, 16'hffff);
    repeat (3) add_request(MODE_ALLOC_ZONE, 16'haaaa);
    add_request(MODE_FREE_ZONE, 16'hfffe);
    add_request(MODE_FREE_ZONE, 16'd0);
    add_request(MODE_FREE_ZONE, 16'hffff);
    wait_drained();
    write_reg(CFG_INODE_BLOCKS, 16'd0);
    write_reg(CFG_ZONE_BLOCKS, 16'd0);
    write_reg(CFG_FIRST_ZONE, 16'd100);
    add_request(MODE_ALLOC_INODE, 16'd0);
    add_request(MODE_FREE_INODE, 16'd5);
    add_request(MODE_ALLOC_ZONE, 16'd0);
    add_request(MODE_FREE_ZONE, 16'd100);
    wait_drained();
    write_reg(CFG_INODE_BLOCKS, 16'd3);
    write_reg(CFG_ZONE_BLOCKS, 16'd15);
    write_reg(CFG_FIRST_ZONE, 16'd0);
    add_request(MODE_ALLOC_INODE, 16'd0);
    add_request(MODE_ALLOC_ZONE, 16'd0);
    add_request(MODE_FREE_INODE, 16'd16383);
    add_request(MODE_FREE_INODE, 16'd16384);
    add_request(MODE_FREE_ZONE, 16'd65534);
    add_request(MODE_FREE_ZONE, 16'd65535);
    wait_drained();
    random_phase();

    send_idle_pct = 55;
    recv_idle_pct = 36;
    random_phase();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase();

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS inode_zone_bitmap_allocator_core");
    end else begin
      $display("FAIL inode_zone_bitmap_allocator_core");
    end
    $finish;
  end

endmodule

### sim.f
hdl/izba_pkg.sv
hdl/izba_ram.sv
hdl/inode_zone_bitmap_allocator_core.sv
hdl/izba_checker.sv
sim/inode_zone_bitmap_allocator_core_test.sv
